// ===== rtl/rhcc_pkg.sv =====
// Shared types and constants of the rolling hash content chunker.
// Used by the modular arithmetic unit and the top level; depends on nothing.
`default_nettype none

package rhcc_pkg;

  localparam int HASH_W = 64;

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t CFG_BASE     = 3'd0;
  localparam cfg_idx_t CFG_MODULUS  = 3'd1;
  localparam cfg_idx_t CFG_WIN_POW  = 3'd2;
  localparam cfg_idx_t CFG_CUT_BITS = 3'd3;
  localparam cfg_idx_t CFG_MIN_SIZE = 3'd4;
  localparam cfg_idx_t CFG_MAX_SIZE = 3'd5;

  localparam logic [HASH_W-1:0] RST_BASE    = 64'd3;
  localparam logic [HASH_W-1:0] RST_MODULUS = 64'hFFFF_FFFF_FFFF_FFC5;
  localparam logic [HASH_W-1:0] RST_WIN_POW = 64'd0;
  localparam logic [5:0]        RST_CUT     = 6'd12;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_H,
    ST_MUL1,
    ST_RED_I,
    ST_ADD_I,
    ST_RED_O,
    ST_MUL2,
    ST_NEG,
    ST_SUB_O,
    ST_FIN,
    ST_ERR
  } st_t;

  typedef struct packed {
    logic        range_error;
    logic        final_chunk;
    logic [31:0] chunk_size;
    logic [31:0] chunk_start;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/rhcc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the window bytes of the chunker.
`default_nettype none

module rhcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  wire                                    clk,
  input  wire                                    we,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire  [WIDTH-1:0]                       wdata,
  input  wire                                    re,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/rhcc_modunit.sv =====
// Shared modular step unit: (x << dbl) + y reduced by m, for x, y below m.
// Modulus zero gives plain 64-bit wrapping. Depends on rhcc_pkg.
`default_nettype none

module rhcc_modunit (
  input  wire  [rhcc_pkg::HASH_W-1:0] x,
  input  wire  [rhcc_pkg::HASH_W-1:0] y,
  input  wire                         dbl,
  input  wire  [rhcc_pkg::HASH_W-1:0] m,
  output logic [rhcc_pkg::HASH_W-1:0] res
);

  import rhcc_pkg::*;

  logic [HASH_W+1:0] s;
  logic [HASH_W+1:0] m1;
  logic [HASH_W+1:0] m2;
  logic [HASH_W+1:0] d1;
  logic [HASH_W+1:0] d2;

  assign m1 = {2'b00, m};
  assign m2 = {1'b0, m, 1'b0};
  assign s  = (dbl ? {1'b0, x, 1'b0} : {2'b00, x}) + {2'b00, y};
  assign d1 = s - m1;
  assign d2 = s - m2;

  always_comb begin
    if (m == '0) begin
      res = s[HASH_W-1:0];
    end else if (s >= m2) begin
      res = d2[HASH_W-1:0];
    end else if (s >= m1) begin
      res = d1[HASH_W-1:0];
    end else begin
      res = s[HASH_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rolling_hash_content_chunker.sv =====
// Content-defined chunker: polynomial rolling hash, one byte per word.
// Per byte: hash times base plus the reduced byte; once rolling, minus the outgoing window
// byte times the window power. After a modulus write the held hash is reduced first. The
// result word can be taken at the same edge as the next byte. Bytes dropped for a minimum
// below the window skip these steps. Bytes are taken only in the idle state; the 64-step
// shift-add multiplies and 8-step byte reductions share one modular adder. rst_n (sync,
// low) loads register defaults and clears the stream state; window RAM is not cleared.
`default_nettype none

module rolling_hash_content_chunker #(
  parameter int WINDOW      = 48,
  parameter int DEFAULT_MIN = 16384,
  parameter int DEFAULT_MAX = 65536,
  parameter int OFFSET_BITS = 32
) (
  input  wire                    clk,
  input  wire                    rst_n,
  // configuration write channel
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire  rhcc_pkg::cfg_idx_t cfg_index,
  input  wire  [63:0]            cfg_data,
  // input stream
  input  wire                    in_tvalid,
  output logic                   in_tready,
  input  wire  [7:0]             in_tdata,   // [7:0] data_byte
  input  wire                    in_tlast,   // last_byte
  // result stream
  output logic                   out_tvalid,
  input  wire                    out_tready,
  output logic [63:0]            out_tdata,  // [31:0] chunk_start, [63:32] chunk_size
  output logic                   out_tlast,  // final_chunk
  output logic                   out_tuser   // range_error
);

  import rhcc_pkg::*;

  localparam int WA = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SW = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

  // configuration registers
  logic [HASH_W-1:0] base_r, mod_r, wpow_r;
  logic [5:0]        cbits_r;
  logic [31:0]       min_r, max_r;

  // sequencer state
  st_t               state_r, state_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic              last_r, last_nxt;
  logic [31:0]       len_r, len_nxt;
  logic              roll_r, roll_nxt;
  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic [HASH_W-1:0] t_r, t_nxt;
  logic [HASH_W-1:0] acc_r, acc_nxt;
  logic [HASH_W-1:0] opa_r, opa_nxt;
  logic [HASH_W-1:0] opb_r, opb_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [WA-1:0]     wptr_r, wptr_nxt;
  logic              dirty_r, dirty_nxt;
  res_t              ores_r, ores_nxt;
  logic              ovalid_r, ovalid_nxt;

  // datapath helpers
  logic [HASH_W-1:0] ux, uy, ures;
  logic              udbl;
  logic              ram_we, ram_re;
  logic [7:0]        ram_rdata;
  logic [31:0]       mn, len_inc;
  logic              small_min, slot_free, hit, cut, need_out;
  logic [HASH_W-1:0] cmask;
  logic [SW-1:0]     start_ext;

  rhcc_modunit u_mod (
    .x   (ux),
    .y   (uy),
    .dbl (udbl),
    .m   (mod_r),
    .res (ures)
  );

  rhcc_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW)
  ) u_win (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wptr_r),
    .wdata (byte_r),
    .re    (ram_re),
    .raddr (wptr_r),
    .rdata (ram_rdata)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= RST_BASE;
      mod_r   <= RST_MODULUS;
      wpow_r  <= RST_WIN_POW;
      cbits_r <= RST_CUT;
      min_r   <= '0;
      max_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BASE:     base_r  <= cfg_data;
        CFG_MODULUS:  mod_r   <= cfg_data;
        CFG_WIN_POW:  wpow_r  <= cfg_data;
        CFG_CUT_BITS: cbits_r <= cfg_data[5:0];
        CFG_MIN_SIZE: min_r   <= cfg_data[31:0];
        CFG_MAX_SIZE: max_r   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (min_r == '0 || max_r == '0) begin
      mn = 32'(DEFAULT_MIN);
    end else begin
      mn = min_r;
    end
  end

  logic [31:0] mx;
  always_comb begin
    if (min_r == '0 || max_r == '0) begin
      mx = 32'(DEFAULT_MAX);
    end else begin
      mx = max_r;
    end
  end

  assign small_min = mn < 32'(WINDOW);
  assign slot_free = !ovalid_r || out_tready;
  assign len_inc   = (len_r != '1) ? len_r + 32'd1 : len_r;
  assign cmask     = ~({HASH_W{1'b1}} << cbits_r);
  assign hit       = (t_r & cmask) == '0;
  assign cut       = (len_r >= 32'(WINDOW)) &&
                     ((hit && len_r >= mn && len_r <= mx) || len_r == mx);
  assign need_out  = last_r || cut;
  assign start_ext = SW'(start_r);

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    byte_nxt   = byte_r;
    last_nxt   = last_r;
    len_nxt    = len_r;
    roll_nxt   = roll_r;
    hash_nxt   = hash_r;
    t_nxt      = t_r;
    acc_nxt    = acc_r;
    opa_nxt    = opa_r;
    opb_nxt    = opb_r;
    cnt_nxt    = cnt_r;
    start_nxt  = start_r;
    wptr_nxt   = wptr_r;
    dirty_nxt  = dirty_r;
    ores_nxt   = ores_r;
    ovalid_nxt = ovalid_r && !out_tready;
    ux         = acc_r;
    uy         = '0;
    udbl       = 1'b1;
    ram_we     = 1'b0;
    ram_re     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          byte_nxt = in_tdata;
          last_nxt = in_tlast;
          if (small_min) begin
            if (in_tlast) begin
              state_nxt = ST_ERR;
            end
          end else begin
            len_nxt  = len_inc;
            roll_nxt = len_inc > 32'(WINDOW);
            ram_re   = 1'b1;
            acc_nxt  = '0;
            cnt_nxt  = 6'd63;
            if (dirty_r) begin
              opb_nxt   = hash_r;
              state_nxt = ST_RED_H;
            end else begin
              opa_nxt   = hash_r;
              opb_nxt   = base_r;
              state_nxt = ST_MUL1;
            end
          end
        end
      end
      ST_RED_H: begin
        uy      = {{(HASH_W-1){1'b0}}, opb_r[HASH_W-1]};
        acc_nxt = ures;
        opb_nxt = opb_r << 1;
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == '0) begin
          opa_nxt   = ures;
          acc_nxt   = '0;
          opb_nxt   = base_r;
          cnt_nxt   = 6'd63;
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        uy      = opb_r[HASH_W-1] ? opa_r : '0;
        acc_nxt = ures;
        opb_nxt = opb_r << 1;
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == '0) begin
          t_nxt     = ures;
          acc_nxt   = '0;
          opb_nxt   = {byte_r, {(HASH_W-8){1'b0}}};
          cnt_nxt   = 6'd7;
          state_nxt = ST_RED_I;
        end
      end
      ST_RED_I: begin
        uy      = {{(HASH_W-1){1'b0}}, opb_r[HASH_W-1]};
        acc_nxt = ures;
        opb_nxt = opb_r << 1;
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == '0) begin
          state_nxt = ST_ADD_I;
        end
      end
      ST_ADD_I: begin
        ux    = t_r;
        uy    = acc_r;
        udbl  = 1'b0;
        t_nxt = ures;
        if (roll_r) begin
          acc_nxt   = '0;
          opb_nxt   = {ram_rdata, {(HASH_W-8){1'b0}}};
          cnt_nxt   = 6'd7;
          state_nxt = ST_RED_O;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_RED_O: begin
        uy      = {{(HASH_W-1){1'b0}}, opb_r[HASH_W-1]};
        acc_nxt = ures;
        opb_nxt = opb_r << 1;
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == '0) begin
          opa_nxt   = ures;
          acc_nxt   = '0;
          opb_nxt   = wpow_r;
          cnt_nxt   = 6'd63;
          state_nxt = ST_MUL2;
        end
      end
      ST_MUL2: begin
        uy      = opb_r[HASH_W-1] ? opa_r : '0;
        acc_nxt = ures;
        opb_nxt = opb_r << 1;
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == '0) begin
          state_nxt = ST_NEG;
        end
      end
      ST_NEG: begin
        // additive inverse of the outgoing term
        acc_nxt   = (acc_r == '0) ? '0 : mod_r - acc_r;
        state_nxt = ST_SUB_O;
      end
      ST_SUB_O: begin
        ux        = t_r;
        uy        = acc_r;
        udbl      = 1'b0;
        t_nxt     = ures;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!need_out || slot_free) begin
          ram_we    = 1'b1;
          wptr_nxt  = (wptr_r == WA'(WINDOW - 1)) ? '0 : wptr_r + WA'(1);
          hash_nxt  = t_r;
          dirty_nxt = 1'b0;
          state_nxt = ST_IDLE;
          if (need_out) begin
            ores_nxt.chunk_start = start_ext[31:0];
            ores_nxt.chunk_size  = len_r;
            ores_nxt.final_chunk = last_r;
            ores_nxt.range_error = 1'b0;
            ovalid_nxt = 1'b1;
            hash_nxt   = '0;
            len_nxt    = '0;
            wptr_nxt   = '0;
            start_nxt  = last_r ? '0 : start_r + OFFSET_BITS'(len_r);
          end
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          ores_nxt   = '0;
          ores_nxt.range_error = 1'b1;
          ovalid_nxt = 1'b1;
          hash_nxt   = '0;
          len_nxt    = '0;
          wptr_nxt   = '0;
          start_nxt  = '0;
          dirty_nxt  = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_valid && cfg_index == CFG_MODULUS) begin
      dirty_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      len_r    <= '0;
      roll_r   <= 1'b0;
      hash_r   <= '0;
      cnt_r    <= '0;
      start_r  <= '0;
      wptr_r   <= '0;
      dirty_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      len_r    <= len_nxt;
      roll_r   <= roll_nxt;
      hash_r   <= hash_nxt;
      cnt_r    <= cnt_nxt;
      start_r  <= start_nxt;
      wptr_r   <= wptr_nxt;
      dirty_r  <= dirty_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    t_r    <= t_nxt;
    acc_r  <= acc_nxt;
    opa_r  <= opa_nxt;
    opb_r  <= opb_nxt;
    ores_r <= ores_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {ores_r.chunk_size, ores_r.chunk_start};
  assign out_tlast  = ores_r.final_chunk;
  assign out_tuser  = ores_r.range_error;

endmodule

`default_nettype wire

// ===== test/rolling_hash_content_chunker_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the rolling hash content chunker. It follows register writes and accepted
// bytes, predicts each chunk word and compares it with the result channel.
// Depends on rhcc_pkg for the register indexes, reset values and the result layout.
module rolling_hash_content_chunker_checker #(
  parameter int WINDOW      = 48,
  parameter int DEFAULT_MIN = 16384,
  parameter int DEFAULT_MAX = 65536,
  parameter int OFFSET_BITS = 32
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      cfg_valid,
  input  wire                      cfg_ready,
  input  wire  rhcc_pkg::cfg_idx_t cfg_index,
  input  wire  [63:0]              cfg_data,
  input  wire                      in_tvalid,
  input  wire                      in_tready,
  input  wire  [7:0]               in_tdata,   // [7:0] data_byte
  input  wire                      in_tlast,   // last_byte
  input  wire                      out_tvalid,
  input  wire                      out_tready,
  input  wire  [63:0]              out_tdata,  // [31:0] chunk_start, [63:32] chunk_size
  input  wire                      out_tlast,  // final_chunk
  input  wire                      out_tuser,  // range_error
  output int                       mismatches,
  output int                       pending
);
  import rhcc_pkg::*;

  logic [63:0]            base_r, mod_r, wpow_r;
  logic [5:0]             cut_r;
  logic [31:0]            min_r, max_r;
  logic [7:0]             win_bytes [WINDOW];
  logic [63:0]            hash_r;
  logic [OFFSET_BITS-1:0] start_r;
  logic [31:0]            len_r;
  int                     wr_idx;
  res_t                   chunk_queue [$];
  int                     n_mismatch = 0;
  int                     n_pending = 0;

  assign mismatches = n_mismatch;
  assign pending    = n_pending;

  // modulus zero means plain 64-bit wrapping arithmetic
  function automatic logic [63:0] mod_red(input logic [63:0] a, input logic [63:0] m);
    return (m == 64'd0) ? a : a % m;
  endfunction

  function automatic logic [63:0] mod_add(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] m);
    logic [64:0] s;
    if (m == 64'd0) return a + b;
    s = {1'b0, a % m} + {1'b0, b % m};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[63:0];
  endfunction

  function automatic logic [63:0] mod_sub(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] m);
    logic [63:0] x, y;
    if (m == 64'd0) return a - b;
    x = a % m;
    y = b % m;
    return (x >= y) ? x - y : x + (m - y);
  endfunction

  function automatic logic [63:0] mod_mul(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] m);
    logic [127:0] p;
    if (m == 64'd0) return a * b;
    p = {64'd0, a % m} * {64'd0, b % m};
    p = p % {64'd0, m};
    return p[63:0];
  endfunction

  task automatic clear_stream();
    hash_r  = '0;
    start_r = '0;
    len_r   = '0;
    wr_idx  = 0;
  endtask

  task automatic queue_chunk(input res_t c);
    chunk_queue = {chunk_queue, c};
  endtask

  task automatic chunk_on_byte(input logic [7:0] b, input logic lst);
    logic [31:0] mn, mx;
    logic [63:0] h, cmask;
    res_t        res;
    mn  = min_r;
    mx  = max_r;
    res = '0;
    if (mn == 32'd0 || mx == 32'd0) begin
      mn = 32'(DEFAULT_MIN);
      mx = 32'(DEFAULT_MAX);
    end
    // minimum below the window: bytes dropped, error word on the last one
    if (mn < WINDOW) begin
      if (lst) begin
        res.range_error = 1'b1;
        queue_chunk(res);
        clear_stream();
      end
      return;
    end
    if (len_r != 32'hFFFF_FFFF) len_r++;
    h = mod_add(mod_mul(hash_r, base_r, mod_r), mod_red({56'd0, b}, mod_r), mod_r);
    if (len_r > WINDOW)
      h = mod_sub(h, mod_mul({56'd0, win_bytes[wr_idx]}, wpow_r, mod_r), mod_r);
    hash_r            = h;
    win_bytes[wr_idx] = b;
    wr_idx            = (wr_idx + 1) % WINDOW;
    if (lst) begin
      res.chunk_start = 32'(start_r);
      res.chunk_size  = len_r;
      res.final_chunk = 1'b1;
      queue_chunk(res);
      clear_stream();
      return;
    end
    if (len_r >= WINDOW) begin
      cmask = (64'd1 << cut_r) - 64'd1;
      if (((hash_r & cmask) == 64'd0 && len_r >= mn && len_r <= mx) || len_r == mx) begin
        res.chunk_start = 32'(start_r);
        res.chunk_size  = len_r;
        queue_chunk(res);
        start_r = start_r + OFFSET_BITS'(len_r);
        hash_r  = '0;
        len_r   = '0;
        wr_idx  = 0;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_v);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_v);
    n_mismatch++;
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      base_r = RST_BASE;
      mod_r  = RST_MODULUS;
      wpow_r = RST_WIN_POW;
      cut_r  = RST_CUT;
      min_r  = '0;
      max_r  = '0;
      clear_stream();
      chunk_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BASE:     base_r = cfg_data;
          CFG_MODULUS:  mod_r  = cfg_data;
          CFG_WIN_POW:  wpow_r = cfg_data;
          CFG_CUT_BITS: cut_r  = cfg_data[5:0];
          CFG_MIN_SIZE: min_r  = cfg_data[31:0];
          CFG_MAX_SIZE: max_r  = cfg_data[31:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) chunk_on_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (chunk_queue.size() == 0) begin
          report_mismatch("word with no chunk due", out_tdata, 64'd0);
        end else begin
          want = chunk_queue.pop_front();
          if (out_tdata[31:0] != want.chunk_start)
            report_mismatch("chunk_start", out_tdata[31:0], want.chunk_start);
          if (out_tdata[63:32] != want.chunk_size)
            report_mismatch("chunk_size", out_tdata[63:32], want.chunk_size);
          if (out_tlast !== want.final_chunk)
            report_mismatch("final_chunk", out_tlast, want.final_chunk);
          if (out_tuser !== want.range_error)
            report_mismatch("range_error", out_tuser, want.range_error);
        end
      end
    end
    n_pending = chunk_queue.size();
  end

endmodule

// ===== test/rolling_hash_content_chunker_tb.sv =====
`timescale 1ns / 1ps
// Testbench top of the rolling hash content chunker: clock, reset, register settings and
// byte streams with random idling on both sides; the verdict comes from the checker count.
// Depends on rhcc_pkg, rolling_hash_content_chunker and rolling_hash_content_chunker_checker.
module rolling_hash_content_chunker_tb;
  import rhcc_pkg::*;

  localparam int WINDOW      = 48;
  localparam int DEFAULT_MIN = 16384;
  localparam int DEFAULT_MAX = 65536;
  localparam int OFFSET_BITS = 32;
  localparam int SETTLE      = 400;
  localparam int HOLD_CYCLES = 15000;
  localparam int LIMIT       = 3000000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_valid  = 1'b0;
  wire         cfg_ready;
  cfg_idx_t    cfg_index  = CFG_BASE;
  logic [63:0] cfg_data   = '0;
  logic        in_tvalid  = 1'b0;
  wire         in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  wire         out_tvalid;
  logic        out_tready = 1'b0;
  wire  [63:0] out_tdata;
  wire         out_tlast;
  wire         out_tuser;
  int          mismatches;
  int          pending;
  int          cycle_cnt  = 0;
  bit          hold_req   = 1'b0;
  bit          hold_done  = 1'b0;
  bit          quiet      = 1'b0;

  rolling_hash_content_chunker #(
    .WINDOW(WINDOW), .DEFAULT_MIN(DEFAULT_MIN), .DEFAULT_MAX(DEFAULT_MAX),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  rolling_hash_content_chunker_checker #(
    .WINDOW(WINDOW), .DEFAULT_MIN(DEFAULT_MIN), .DEFAULT_MAX(DEFAULT_MAX),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .mismatches(mismatches), .pending(pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: short random stalls, a few long ones, calm stretches, one long hold-off
  initial begin : receiver
    int stall;
    int beat;
    int r;
    bit calm;
    stall = 0;
    beat  = 0;
    calm  = 1'b0;
    forever begin
      @(negedge clk);
      beat++;
      if (beat % 3000 == 0) calm = ($urandom_range(0, 2) == 0);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        if (!calm) begin
          r = $urandom_range(0, 99);
          if (r < 15) stall = $urandom_range(1, 4);
          else if (r < 18) stall = $urandom_range(20, 150);
        end
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_word(input logic [7:0] b, input logic lst);
    int gap;
    int r;
    gap = 0;
    if (!quiet) begin
      r = $urandom_range(0, 99);
      if (r >= 93) gap = $urandom_range(10, 100);
      else if (r >= 70) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= b;
    in_tlast  <= lst;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] random_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'h00;
    if (r < 16) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_streams(input int budget);
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < budget) begin
      r = $urandom_range(0, 99);
      if (r < 50) len = $urandom_range(1, 60);
      else if (r < 90) len = $urandom_range(61, 250);
      else len = $urandom_range(251, 600);
      if (len > budget - sent) len = budget - sent;
      quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) send_word(random_byte(), i == len - 1);
      sent += len;
    end
  endtask

  // wait until every chunk word is back, then let a byte still in flight finish
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic configure(input logic [63:0] base, input logic [63:0] modulus,
                           input logic [63:0] wpow, input logic [5:0] cut,
                           input logic [31:0] mn, input logic [31:0] mx);
    drain();
    write_reg(CFG_BASE, base);
    write_reg(CFG_MODULUS, modulus);
    write_reg(CFG_WIN_POW, wpow);
    write_reg(CFG_CUT_BITS, {58'd0, cut});
    write_reg(CFG_MIN_SIZE, {32'd0, mn});
    write_reg(CFG_MAX_SIZE, {32'd0, mx});
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: single-byte stream, byte extremes
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h01, 1'b0);
    send_word(8'h7F, 1'b0);
    send_word(8'hFE, 1'b1);
    send_streams(120);

    configure(64'd257, RST_MODULUS, {$urandom, $urandom}, 6'd4, 32'd48, 32'd128);
    send_streams(350);

    // every check hits, cut at the window size; receiver holds off meanwhile
    configure('1, 64'd0, '1, 6'd0, 32'd48, 32'd48);
    hold_req = 1'b1;
    send_streams(300);

    // minimum below the window
    configure(64'd0, 64'd1, 64'd0, 6'd63, 32'd1, 32'hFFFF_FFFF);
    send_word(8'h12, 1'b1);
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h33, 1'b1);
    send_streams(80);

    // zero max selects the defaults, so the low minimum does not matter
    configure({$urandom, $urandom}, {1'b1, 31'($urandom), 32'($urandom)},
              {$urandom, $urandom}, 6'd2, 32'd47, 32'd0);
    send_streams(120);

    configure(64'd31, 64'd1000003, {$urandom, $urandom}, 6'd5, 32'd47, 32'd100);
    send_streams(60);

    // maximum below the window: tails only
    configure({$urandom, $urandom}, 64'd2, {$urandom, $urandom}, 6'd1, 32'd48, 32'd20);
    send_streams(150);

    configure({$urandom, $urandom}, '1, {$urandom, $urandom}, 6'd6, 32'd200, 32'd300);
    send_streams(300);

    // minimum above maximum: only the forced cut at max
    configure(64'd3, {$urandom, $urandom}, {$urandom, $urandom}, 6'd3, 32'd100, 32'd50);
    send_streams(250);

    configure({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}, 6'd63,
              32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_streams(80);

    configure({$urandom, $urandom}, 64'd0, {$urandom, $urandom}, 6'd3, 32'd0, 32'd500);
    send_streams(100);

    drain();
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
